// File: design/linear_probe_hash_table_unit_assert.svh
// assertion macros for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LPHT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lpht assertion failed");
`define LPHT_NEVER(label, clk, rst_n, cond) \
	`LPHT_ASSERT(label, clk, rst_n, !(cond))
`else
`define LPHT_ASSERT(label, clk, rst_n, prop)
`define LPHT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int KEY_BITS_DEF = 64;

	localparam int KEY_W = 64;
	localparam int HASH_W = 64;
	localparam int VALUE_W = 32;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef enum logic [2:0] {
		STATUS_FOUND = 3'd0,
		STATUS_NOT_FOUND = 3'd1,
		STATUS_INSERTED = 3'd2,
		STATUS_UPDATED = 3'd3,
		STATUS_REJECTED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK
	} state_t;

endpackage
`default_nettype wire

// File: design/lpht_req_if.sv
`default_nettype none
interface lpht_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [lpht_pkg::KEY_W-1:0] key;
	logic [lpht_pkg::HASH_W-1:0] hash;
	logic [lpht_pkg::VALUE_W-1:0] value;

	modport source (output valid, req_type, key, hash, value, input ready);
	modport sink (input valid, req_type, key, hash, value, output ready);
endinterface
`default_nettype wire

// File: design/lpht_rsp_if.sv
`default_nettype none
interface lpht_rsp_if;
	logic valid;
	logic ready;
	lpht_pkg::status_t status;
	logic [lpht_pkg::VALUE_W-1:0] found_value;

	modport source (output valid, status, found_value, input ready);
	modport sink (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

// File: design/lpht_store.sv
`default_nettype none
module lpht_store #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 97,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: design/linear_probe_hash_table_unit.sv
// Linear probing hash table unit.
// req channel: req_type (lookup or insert/update), key, hash and value.
// rsp channel: one item per request, status and found_value.
// Probing starts at the low hash bits, steps one slot per cycle and wraps;
// it ends at a matching key, an empty slot or after CAPACITY slots. An
// item is accepted in ST_IDLE and probed in ST_CHECK, where each probe
// is one registered read of the slot memory; the probe length is at
// least one slot and at most CAPACITY.
// A new key is refused once the table holds CAPACITY/2 entries, and any
// insert with a zero value is refused.
// After reset the slot memory is cleared one slot per cycle, while
// req.ready stays low.
// The result sits in an output register; req.ready returns as soon as a
// result is registered, so the next item is taken while rsp is stalled.
// A finished probe waits with its write until the output register frees,
// so nothing is lost or repeated under a stalled receiver.
`default_nettype none
`include "linear_probe_hash_table_unit_assert.svh"
module linear_probe_hash_table_unit #(
	parameter int CAPACITY = lpht_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lpht_req_if.sink req,
	lpht_rsp_if.source rsp
);

	import lpht_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int ENTRY_W = 1 + KEY_BITS + VALUE_W;
	localparam logic [IDX_W-1:0] HALF = IDX_W'(CAPACITY / 2);

	state_t state_q;
	state_t state_d;

	logic req_type_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] probes_q;
	logic [IDX_W-1:0] count_q;

	logic rsp_valid_q;
	status_t rsp_status_q;
	logic [VALUE_W-1:0] rsp_value_q;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	logic slot_valid;
	logic [KEY_BITS-1:0] slot_key;
	logic [VALUE_W-1:0] slot_value;

	logic accept;
	logic out_free;
	logic hit;
	logic zero_ins;
	logic done;
	logic fire;
	logic grow;
	status_t res_status;
	logic [VALUE_W-1:0] res_value;

	lpht_store #(
		.DEPTH(CAPACITY),
		.WIDTH(ENTRY_W)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign slot_valid = rd_data[ENTRY_W-1];
	assign slot_key = rd_data[VALUE_W +: KEY_BITS];
	assign slot_value = rd_data[VALUE_W-1:0];

	assign accept = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign hit = slot_valid && (slot_key == key_q);
	assign zero_ins = (req_type_q == REQ_INSERT) && (value_q == '0);
	assign done = zero_ins || hit || !slot_valid || (probes_q == '1);
	assign fire = (state_q == ST_CHECK) && done && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		rd_addr = idx_q;
		grow = 1'b0;
		res_status = STATUS_REJECTED;
		res_value = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				rd_addr = req.hash[IDX_W-1:0];
			end
			ST_CHECK: begin
				wr_data = {1'b1, key_q, value_q};
				if (!done) begin
					rd_addr = idx_q + IDX_W'(1);
				end
				if (zero_ins) begin
					res_status = STATUS_REJECTED;
				end else if (req_type_q == REQ_LOOKUP) begin
					if (hit) begin
						res_status = STATUS_FOUND;
						res_value = slot_value;
					end else begin
						res_status = STATUS_NOT_FOUND;
					end
				end else if (hit) begin
					res_status = STATUS_UPDATED;
					wr_en = fire;
				end else if (!slot_valid && (count_q < HALF)) begin
					res_status = STATUS_INSERTED;
					wr_en = fire;
					grow = fire;
				end else begin
					res_status = STATUS_REJECTED;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			probes_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				idx_q <= idx_q + IDX_W'(1);
			end else if (accept) begin
				idx_q <= req.hash[IDX_W-1:0];
				probes_q <= '0;
			end else if (state_q == ST_CHECK && !done) begin
				idx_q <= idx_q + IDX_W'(1);
				probes_q <= probes_q + IDX_W'(1);
			end
			if (grow) begin
				count_q <= count_q + IDX_W'(1);
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			key_q <= req.key[KEY_BITS-1:0];
			value_q <= req.value;
		end
		if (fire) begin
			rsp_status_q <= res_status;
			rsp_value_q <= res_value;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found_value = rsp_value_q;

	`LPHT_NEVER(a_count_bound, clk, arst_n, count_q > HALF)
	`LPHT_ASSERT(a_write_state, clk, arst_n, wr_en |-> (state_q == ST_CHECK || state_q == ST_CLEAR))
	`LPHT_ASSERT(a_count_step, clk, arst_n, (count_q != $past(count_q)) |-> (rsp.valid && rsp.status == STATUS_INSERTED))
	`LPHT_ASSERT(a_probe_start, clk, arst_n, accept |=> (state_q == ST_CHECK && probes_q == '0))

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import lpht_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int SLOT_BITS = $clog2(CAP);
	localparam int POOL = 160;

	typedef struct {
		status_t status;
		logic [VALUE_W-1:0] found_value;
	} rsp_item_t;

	logic clk;
	logic arst_n;

	lpht_req_if req();
	lpht_rsp_if rsp();

	linear_probe_hash_table_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// shadow of the table contents
	logic tbl_valid [CAP];
	logic [KEY_W-1:0] tbl_key [CAP];
	logic [VALUE_W-1:0] tbl_value [CAP];
	int unsigned tbl_count;

	rsp_item_t expected_rsp [$];
	logic [KEY_W-1:0] key_pool [POOL];
	logic [SLOT_BITS-1:0] pool_slot [POOL];

	bit src_idle_en;
	bit snk_idle_en;
	int rsp_hold_cycles;
	int mismatches;
	int requests_sent;
	int responses_checked;
	int status_seen [5];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic rsp_item_t predict_table_response(logic rt, logic [KEY_W-1:0] k,
			logic [HASH_W-1:0] h, logic [VALUE_W-1:0] v);
		rsp_item_t r;
		int idx;
		int where;
		bit hit;
		bit have_empty;
		r.status = STATUS_REJECTED;
		r.found_value = '0;
		hit = 1'b0;
		have_empty = 1'b0;
		where = 0;
		if (rt == REQ_INSERT && v == '0)
			return r;
		idx = int'(h[SLOT_BITS-1:0]);
		for (int n = 0; n < CAP; n++) begin
			if (!tbl_valid[idx]) begin
				where = idx;
				have_empty = 1'b1;
				break;
			end
			if (tbl_key[idx] == k) begin
				where = idx;
				hit = 1'b1;
				break;
			end
			idx = (idx + 1) % CAP;
		end
		if (rt == REQ_LOOKUP) begin
			if (hit) begin
				r.status = STATUS_FOUND;
				r.found_value = tbl_value[where];
			end else begin
				r.status = STATUS_NOT_FOUND;
			end
		end else if (hit) begin
			tbl_value[where] = v;
			r.status = STATUS_UPDATED;
		end else if (tbl_count < CAP / 2 && have_empty) begin
			tbl_valid[where] = 1'b1;
			tbl_key[where] = k;
			tbl_value[where] = v;
			tbl_count++;
			r.status = STATUS_INSERTED;
		end
		return r;
	endfunction

	task automatic send_request(input logic rt, input logic [KEY_W-1:0] k,
			input logic [HASH_W-1:0] h, input logic [VALUE_W-1:0] v);
		int gap;
		gap = src_idle_en ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.key <= k;
		req.hash <= h;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
		expected_rsp.push_back(predict_table_response(rt, k, h, v));
		requests_sent++;
	endtask

	task automatic stop_requests;
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_all_responses;
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// mostly known keys at their home slot, some fresh keys and stray hashes
	task automatic send_random_request(input int insert_pct);
		logic rt;
		logic [KEY_W-1:0] k;
		logic [HASH_W-1:0] h;
		logic [VALUE_W-1:0] v;
		int p;
		int r;
		rt = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
		p = $urandom_range(0, POOL - 1);
		k = key_pool[p];
		h = {$urandom, $urandom};
		h[SLOT_BITS-1:0] = pool_slot[p];
		r = $urandom_range(0, 99);
		if (r < 5)
			k = {$urandom, $urandom};
		else if (r < 10)
			h[SLOT_BITS-1:0] = SLOT_BITS'($urandom);
		v = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
		send_request(rt, k, h, v);
	endtask

	task automatic check_response;
		rsp_item_t want;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected item, status %0d found_value %h", $time,
				rsp.status, rsp.found_value);
			mismatches++;
		end else begin
			want = expected_rsp.pop_front();
			responses_checked++;
			if (int'(rsp.status) < 5)
				status_seen[int'(rsp.status)]++;
			if (rsp.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					rsp.status);
				mismatches++;
			end
			if (rsp.found_value !== want.found_value) begin
				$display("%0t: found_value expected %h actual %h", $time,
					want.found_value, rsp.found_value);
				mismatches++;
			end
		end
	endtask

	initial begin : rsp_sink
		int stall;
		stall = 0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				check_response();
				stall = snk_idle_en ? $urandom_range(0, 3) : 0;
			end
			if (rsp_hold_cycles > 0) begin
				rsp_hold_cycles--;
				rsp.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic test_directed;
		send_request(REQ_LOOKUP, '0, '1, 32'h1);
		send_request(REQ_INSERT, '0, '0, '0);
		send_request(REQ_INSERT, '0, '0, 32'h1);
		send_request(REQ_INSERT, '1, '1, '1);
		// wraps from the last slot past slot 0
		send_request(REQ_INSERT, 64'h5a5a_a5a5_0f0f_f0f0, 64'h0123_4567_89ab_cdff,
			32'h8000_0000);
		send_request(REQ_LOOKUP, 64'h5a5a_a5a5_0f0f_f0f0, 64'hffff_0000_ffff_00ff, '0);
		send_request(REQ_LOOKUP, '1, '1, '0);
		send_request(REQ_INSERT, '0, 64'hffff_ffff_ffff_ff00, 32'h1234_5678);
		send_request(REQ_INSERT, '0, '0, '0);
		send_request(REQ_LOOKUP, '0, '0, '1);
		send_request(REQ_LOOKUP, 64'h0000_0000_dead_beef, '1, '0);
		send_request(REQ_LOOKUP, '1, '0, '0);
		send_request(REQ_INSERT, 64'h1, 64'h1, 32'h7);
		send_request(REQ_LOOKUP, 64'h1, 64'hffff_ffff_ffff_ff01, '0);
		send_request(REQ_LOOKUP, 64'h5a5a_a5a5_0f0f_f0f0, '0, '0);
		send_request(REQ_INSERT, '1, '1, 32'h5555_aaaa);
		send_request(REQ_LOOKUP, '1, 64'h8000_0000_0000_00ff, '0);
		stop_requests();
	endtask

	task automatic test_random_traffic(input int n, input int insert_pct);
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) begin
				src_idle_en = ($urandom_range(0, 3) != 0);
				snk_idle_en = ($urandom_range(0, 3) != 0);
			end
			send_random_request(insert_pct);
		end
		stop_requests();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	task automatic test_backpressure;
		src_idle_en = 1'b0;
		rsp_hold_cycles = 400;
		for (int i = 0; i < 60; i++)
			send_random_request(30);
		stop_requests();
		src_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause;
		for (int b = 0; b < 2; b++) begin
			for (int i = 0; i < 40; i++)
				send_random_request(30);
			stop_requests();
			wait_all_responses();
		end
	endtask

	// fresh keys into the crowded slots until new keys are refused
	task automatic test_fill_up;
		logic [HASH_W-1:0] h;
		while (tbl_count < CAP / 2) begin
			h = {$urandom, $urandom};
			h[SLOT_BITS-1:0] = pool_slot[$urandom_range(0, POOL - 1)];
			send_request(REQ_INSERT, {$urandom, $urandom}, h, $urandom | 32'h1);
		end
		for (int i = 0; i < 8; i++)
			send_request(REQ_INSERT, {$urandom, $urandom}, {$urandom, $urandom},
				$urandom | 32'h1);
		for (int i = 0; i < 8; i++)
			send_random_request(100);
		stop_requests();
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_LOOKUP;
		req.key <= '0;
		req.hash <= '0;
		req.value <= '0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		rsp_hold_cycles = 0;
		mismatches = 0;
		requests_sent = 0;
		responses_checked = 0;
		tbl_count = 0;
		for (int i = 0; i < 5; i++)
			status_seen[i] = 0;
		for (int i = 0; i < CAP; i++)
			tbl_valid[i] = 1'b0;
		for (int i = 0; i < POOL; i++) begin
			key_pool[i] = {$urandom, $urandom};
			case (i % 3)
				0: pool_slot[i] = SLOT_BITS'(CAP - 8 + $urandom_range(0, 7));
				1: pool_slot[i] = SLOT_BITS'(16 + $urandom_range(0, 7));
				default: pool_slot[i] = SLOT_BITS'($urandom);
			endcase
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(400, 15);
		test_backpressure();
		test_drain_pause();
		test_fill_up();
		test_random_traffic(1200, 50);

		wait_all_responses();
		repeat (CAP + 50) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, expected_rsp.size());
			mismatches++;
		end
		$display("%0d items sent, %0d checked, table held %0d of %0d slots, %0d mismatches",
			requests_sent, responses_checked, tbl_count, CAP, mismatches);
		$display("found %0d, missing %0d, added %0d, updated %0d, refused %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		if (mismatches == 0) begin
			$display("linear_probe_hash_table_unit regression: pass");
		end else begin
			$display("linear_probe_hash_table_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#25_000_000;
		$display("%0t: timeout", $time);
		$display("linear_probe_hash_table_unit regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/lpht_pkg.sv
design/lpht_req_if.sv
design/lpht_rsp_if.sv
design/lpht_store.sv
design/linear_probe_hash_table_unit.sv
test/tb_top.sv
